// ===== rtl/mcd_pkg.sv =====
// Shared types, register indexes, status codes and helpers for the marker chunk deframer.
// No dependencies; imported by every module of the block.
package mcd_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_START_MARKER = 3'd0;
    localparam logic [2:0] REG_START_LENGTH = 3'd1;
    localparam logic [2:0] REG_END_MARKER   = 3'd2;
    localparam logic [2:0] REG_END_LENGTH   = 3'd3;
    localparam logic [2:0] REG_CHUNK_COUNT  = 3'd4;
    localparam logic [2:0] REG_SIZE_CODES   = 3'd5;
    localparam logic [2:0] REG_BIG_ENDIAN   = 3'd6;
    localparam logic [2:0] REG_SIGNED_MASK  = 3'd7;

    // result status codes
    localparam logic [1:0] ST_CHUNK    = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    // result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [31:0] start_marker;
        logic [2:0]  start_length;
        logic [31:0] end_marker;
        logic [2:0]  end_length;
        logic [4:0]  chunk_count;
        logic [31:0] chunk_size_codes;
        logic        big_endian;
        logic [15:0] signed_mask;
    } cfg_t;

    // one result as the front classifies it; the back finishes the value
    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] raw;
        logic [2:0]  nbytes;
        logic        sx;
        logic [1:0]  status;
        logic        fe;
    } res_t;

    function automatic logic [31:0] low_mask(input logic [2:0] nbytes);
        logic [31:0] m;
        unique case (nbytes)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/mcd_front.sv =====
// Front end: per-byte frame parser (marker hunt, chunk cutting, end check).
// Depends on mcd_pkg; pushes classified results into mcd_queue.
module mcd_front
    import mcd_pkg::*;
#(
    parameter int MAX_CHUNKS       = 16,
    parameter int MAX_MARKER_BYTES = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    output logic       push,
    output res_t       push_data
);

    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int MW = $clog2(MAX_MARKER_BYTES + 1);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_CHUNKS = 2'd1;
    localparam logic [1:0] PH_END    = 2'd2;

    logic [1:0]    phase_reg,  phase_next;
    logic [31:0]   window_reg, window_next;
    logic [MW-1:0] fill_reg,   fill_next;
    logic [CW-1:0] cur_reg,    cur_next;
    logic [2:0]    bic_reg,    bic_next;
    logic [31:0]   acc_reg,    acc_next;
    logic [MW-1:0] ebs_reg,    ebs_next;

    logic [MW-1:0] sl, el;
    logic [CW-1:0] cc;
    logic [31:0]   start_mask;
    logic [31:0]   win_shift;

    logic [1:0]    ph;
    logic          done;
    logic          go_hunt;
    logic [CW-1:0] cur_e, cur_new;
    logic [2:0]    bic_e, bic_new;
    logic [31:0]   acc_e, acc_new, raw;
    logic [MW-1:0] ebs_e, ebs_new;
    logic [2:0]    size;
    logic [1:0]    eshift;
    logic [7:0]    expect_byte;

    function automatic logic [2:0] size_of(input logic [1:0] code);
        logic [2:0] s;
        unique case (code)
            2'd0:       s = 3'd1;
            2'd1:       s = 3'd2;
            2'd2, 2'd3: s = 3'd4;
        endcase
        return s;
    endfunction

    function automatic logic top_bit(input logic [31:0] v, input logic [2:0] nbytes);
        logic t;
        priority case (nbytes)
            3'd1:    t = v[7];
            3'd2:    t = v[15];
            default: t = v[31];
        endcase
        return t;
    endfunction

    assign sl = (cfg.start_length > 3'(MAX_MARKER_BYTES)) ? MW'(MAX_MARKER_BYTES)
                                                          : cfg.start_length[MW-1:0];
    assign el = (cfg.end_length > 3'(MAX_MARKER_BYTES)) ? MW'(MAX_MARKER_BYTES)
                                                        : cfg.end_length[MW-1:0];
    assign cc = (cfg.chunk_count > 5'(MAX_CHUNKS)) ? CW'(MAX_CHUNKS) : CW'(cfg.chunk_count);
    assign start_mask = low_mask(3'(sl));
    assign win_shift  = {window_reg[23:0], data_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        cur_next    = cur_reg;
        bic_next    = bic_reg;
        acc_next    = acc_reg;
        ebs_next    = ebs_reg;
        push        = 1'b0;
        push_data   = '0;
        done        = 1'b0;
        go_hunt     = 1'b0;
        ph          = phase_reg;
        cur_e       = cur_reg;
        bic_e       = bic_reg;
        acc_e       = acc_reg;
        ebs_e       = ebs_reg;
        cur_new     = '0;
        bic_new     = '0;
        acc_new     = '0;
        ebs_new     = '0;
        raw         = '0;
        size        = 3'd1;
        eshift      = '0;
        expect_byte = '0;

        if (in_fire)
        begin
            if (phase_reg == PH_HUNT)
            begin
                if (sl != '0)
                begin
                    done        = 1'b1;
                    window_next = win_shift;
                    if (fill_reg < sl)
                        fill_next = MW'(fill_reg + 1'b1);
                    if (fill_next >= sl &&
                        (win_shift & start_mask) == (cfg.start_marker & start_mask))
                    begin
                        if (cc == '0 && el == '0)
                        begin
                            // marker-only frame
                            go_hunt          = 1'b1;
                            push             = 1'b1;
                            push_data.status = ST_DONE;
                            push_data.fe     = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_CHUNKS;
                            cur_next   = '0;
                            bic_next   = '0;
                            acc_next   = '0;
                            ebs_next   = '0;
                        end
                    end
                end
                else
                begin
                    // no start marker: this byte already belongs to the frame
                    ph    = PH_CHUNKS;
                    cur_e = '0;
                    bic_e = '0;
                    acc_e = '0;
                    ebs_e = '0;
                end
            end

            if (!done)
            begin
                if (ph == PH_CHUNKS && cur_e >= cc)
                begin
                    ph    = PH_END;
                    ebs_e = '0;
                end

                if (ph == PH_CHUNKS)
                begin
                    size    = size_of(cfg.chunk_size_codes[{4'(cur_e), 1'b0} +: 2]);
                    acc_new = cfg.big_endian ? {acc_e[23:0], data_byte}
                                             : acc_e | ({24'd0, data_byte} << {bic_e[1:0], 3'b000});
                    bic_new = bic_e + 3'd1;
                    if (bic_new >= size)
                    begin
                        raw              = acc_new & low_mask(size);
                        push             = 1'b1;
                        push_data.idx    = 4'(cur_e);
                        push_data.raw    = raw;
                        push_data.nbytes = size;
                        push_data.sx     = cfg.signed_mask[4'(cur_e)] & top_bit(raw, size);
                        push_data.status = ST_CHUNK;
                        cur_new          = CW'(cur_e + 1'b1);
                        phase_next       = PH_CHUNKS;
                        cur_next         = cur_new;
                        bic_next         = '0;
                        acc_next         = '0;
                        ebs_next         = ebs_e;
                        if (cur_new >= cc)
                        begin
                            if (el != '0)
                            begin
                                phase_next = PH_END;
                                ebs_next   = '0;
                            end
                            else
                            begin
                                push_data.fe = 1'b1;
                                go_hunt      = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = PH_CHUNKS;
                        cur_next   = cur_e;
                        bic_next   = bic_new;
                        acc_next   = acc_new;
                        ebs_next   = ebs_e;
                    end
                end
                else
                begin
                    // end marker, first byte taken from the most significant used byte
                    cur_next    = cur_e;
                    bic_next    = bic_e;
                    acc_next    = acc_e;
                    eshift      = 2'(3'(el) - 3'd1 - 3'(ebs_e));
                    expect_byte = cfg.end_marker[{eshift, 3'b000} +: 8];
                    ebs_new     = MW'(ebs_e + 1'b1);
                    if (ebs_e >= el)
                    begin
                        go_hunt          = 1'b1;
                        push             = 1'b1;
                        push_data.status = ST_DONE;
                        push_data.fe     = 1'b1;
                    end
                    else if (data_byte != expect_byte)
                    begin
                        go_hunt          = 1'b1;
                        push             = 1'b1;
                        push_data.status = ST_MISMATCH;
                        push_data.fe     = 1'b1;
                    end
                    else if (ebs_new >= el)
                    begin
                        go_hunt          = 1'b1;
                        push             = 1'b1;
                        push_data.status = ST_DONE;
                        push_data.fe     = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_END;
                        ebs_next   = ebs_new;
                    end
                end
            end

            if (go_hunt)
            begin
                phase_next  = PH_HUNT;
                window_next = '0;
                fill_next   = '0;
                cur_next    = '0;
                bic_next    = '0;
                acc_next    = '0;
                ebs_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= '0;
            fill_reg   <= '0;
            cur_reg    <= '0;
            bic_reg    <= '0;
            acc_reg    <= '0;
            ebs_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            cur_reg    <= cur_next;
            bic_reg    <= bic_next;
            acc_reg    <= acc_next;
            ebs_reg    <= ebs_next;
        end
    end

endmodule

// ===== rtl/mcd_queue.sv =====
// Short result queue decoupling the parser from the output stage.
// Depends on mcd_pkg (res_t, QDEPTH, QAW).
module mcd_queue
    import mcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    input  logic pop,
    output logic rd_valid,
    output res_t rd_data
);

    res_t           mem [QDEPTH];
    res_t           head_reg;
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg,  count_next;

    assign full        = (count_reg == (QAW+1)'(QDEPTH));
    assign rd_valid    = (count_reg != '0);
    assign rd_data     = head_reg;
    assign rd_ptr_next = pop ? QAW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // head entry is read ahead; a write into the slot about to become head bypasses the array
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
        if (push && wr_ptr_reg == rd_ptr_next)
            head_reg <= push_data;
        else
            head_reg <= mem[rd_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= QAW'(wr_ptr_reg + 1'b1);
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rd_valid)
        else $error("result queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("result queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QAW'(wr_ptr_reg - rd_ptr_reg) == QAW'(count_reg))
        else $error("result queue pointers disagree with count");

endmodule

// ===== rtl/mcd_back.sv =====
// Back end: sign-extends queued results and holds them in the output register.
// Depends on mcd_pkg (res_t, low_mask).
module mcd_back
    import mcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_valid,
    input  res_t        rd_data,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // chunk_index[3:0], chunk_value[36:4], status[38:37], zero pad
    output logic        m_tlast    // frame_end
);

    logic               valid_reg;
    logic [3:0]         idx_reg;
    logic signed [32:0] value_reg;
    logic [1:0]         status_reg;
    logic               fe_reg;
    logic [32:0]        value_ext;

    assign pop = rd_valid && (!valid_reg || m_tready);

    // set every bit above the chunk's top byte when it is a negative signed chunk
    assign value_ext = {1'b0, rd_data.raw}
                     | (rd_data.sx ? ~{1'b0, low_mask(rd_data.nbytes)} : 33'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            idx_reg    <= rd_data.idx;
            value_reg  <= value_ext;
            status_reg <= rd_data.status;
            fe_reg     <= rd_data.fe;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, status_reg, value_reg, idx_reg};
    assign m_tlast  = fe_reg;

endmodule

// ===== rtl/marker_chunk_deframer.sv =====
// Marker chunk deframer: byte stream in, chunk values and frame status out.
// Usage:
//   s_* carries one received byte per item. The block hunts for the start
//   marker, cuts the configured chunks, checks the end marker, then hunts again.
//   m_* carries results: a value for each chunk, then frame complete or end
//   mismatch unless the last chunk ends the frame; m_tlast marks a frame's last result.
//   Configuration is written through wr_en/wr_index/wr_data while no frame
//   result is outstanding; one write per cycle, no read-back.
// Flow:
//   One byte is taken every cycle while the queue is not full; the parser
//   updates its state once per byte. A result reaches m_tvalid through the
//   parser, then the 4-entry queue, then the output register.
// Reset:
//   rst_n clears the parser to hunting, empties the queue and drops m_tvalid;
//   all configuration registers read zero.
// Back-pressure:
//   While m_tready is low the result stays on m_* and later results gather in
//   the queue; s_tready falls only when the queue is full.
module marker_chunk_deframer
    import mcd_pkg::*;
#(
    parameter int MAX_CHUNKS       = 16,
    parameter int MAX_MARKER_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // chunk_index[3:0], chunk_value[36:4], status[38:37], zero pad
    output logic        m_tlast,   // frame_end
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data
);

    cfg_t cfg_reg;
    logic in_fire;
    logic push;
    res_t push_data;
    logic q_full;
    logic pop;
    logic rd_valid;
    res_t rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_START_MARKER: cfg_reg.start_marker     <= wr_data;
                REG_START_LENGTH: cfg_reg.start_length     <= wr_data[2:0];
                REG_END_MARKER:   cfg_reg.end_marker       <= wr_data;
                REG_END_LENGTH:   cfg_reg.end_length       <= wr_data[2:0];
                REG_CHUNK_COUNT:  cfg_reg.chunk_count      <= wr_data[4:0];
                REG_SIZE_CODES:   cfg_reg.chunk_size_codes <= wr_data;
                REG_BIG_ENDIAN:   cfg_reg.big_endian       <= wr_data[0];
                REG_SIGNED_MASK:  cfg_reg.signed_mask      <= wr_data[15:0];
            endcase
        end
    end

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    mcd_front #(
        .MAX_CHUNKS       (MAX_CHUNKS),
        .MAX_MARKER_BYTES (MAX_MARKER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_fire   (in_fire),
        .data_byte (s_tdata),
        .push      (push),
        .push_data (push_data)
    );

    mcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .rd_valid  (rd_valid),
        .rd_data   (rd_data)
    );

    mcd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/marker_chunk_deframer_test.sv =====
// Self-checking testbench for marker_chunk_deframer: directed frames, then random frames and noise.
// A scoreboard class predicts each result from the accepted bytes; depends on mcd_pkg and the RTL.
module marker_chunk_deframer_test;
    import mcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_BYTES = 650;

    typedef enum logic [1:0] {P_HUNT, P_CHUNKS, P_END} parse_phase_t;

    typedef struct packed {
        logic [3:0]  idx;
        logic [32:0] value;
        logic [1:0]  status;
        logic        fe;
    } chunk_result_t;

    class chunk_scoreboard;
        logic [31:0] start_marker;
        logic [2:0]  start_len;
        logic [31:0] end_marker;
        logic [2:0]  end_len;
        logic [4:0]  chunk_count;
        logic [31:0] size_codes;
        logic        big_endian;
        logic [15:0] signed_mask;

        parse_phase_t phase;
        logic [31:0]  window;
        int           fill;
        int           cur_chunk;
        int           byte_cnt;
        logic [31:0]  acc;
        int           end_seen;

        chunk_result_t pending_results[$];
        int            errors;

        function new();
            start_marker = '0;
            start_len    = '0;
            end_marker   = '0;
            end_len      = '0;
            chunk_count  = '0;
            size_codes   = '0;
            big_endian   = 1'b0;
            signed_mask  = '0;
            errors       = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            phase     = P_HUNT;
            window    = '0;
            fill      = 0;
            cur_chunk = 0;
            byte_cnt  = 0;
            acc       = '0;
            end_seen  = 0;
        endfunction

        function void open_frame();
            phase     = P_CHUNKS;
            cur_chunk = 0;
            byte_cnt  = 0;
            acc       = '0;
            end_seen  = 0;
        endfunction

        function logic [31:0] byte_mask(int n);
            return (n >= 4) ? 32'hffff_ffff : ((32'd1 << (8 * n)) - 32'd1);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            unique case (idx)
                REG_START_MARKER: start_marker = data;
                REG_START_LENGTH: start_len    = data[2:0];
                REG_END_MARKER:   end_marker   = data;
                REG_END_LENGTH:   end_len      = data[2:0];
                REG_CHUNK_COUNT:  chunk_count  = data[4:0];
                REG_SIZE_CODES:   size_codes   = data;
                REG_BIG_ENDIAN:   big_endian   = data[0];
                REG_SIGNED_MASK:  signed_mask  = data[15:0];
            endcase
        endfunction

        function void post(logic [3:0] i, logic [32:0] v, logic [1:0] s, logic f);
            chunk_result_t r;
            r.idx    = i;
            r.value  = v;
            r.status = s;
            r.fe     = f;
            pending_results.push_back(r);
        endfunction

        // advance the parser by one accepted byte
        function void take_byte(logic [7:0] b);
            int          sl, el, cc, code, size, idx;
            logic [31:0] m;
            logic [32:0] raw;
            logic        fe;
            logic [7:0]  want;
            sl = (start_len > 4) ? 4 : int'(start_len);
            el = (end_len > 4) ? 4 : int'(end_len);
            cc = (chunk_count > 16) ? 16 : int'(chunk_count);

            if (phase == P_HUNT)
            begin
                if (sl > 0)
                begin
                    window = {window[23:0], b};
                    if (fill < sl)
                        fill++;
                    m = byte_mask(sl);
                    if (fill >= sl && (window & m) == (start_marker & m))
                    begin
                        open_frame();
                        if (cc == 0 && el == 0)
                        begin
                            restart_hunt();
                            post(4'd0, 33'd0, ST_DONE, 1'b1);
                        end
                    end
                    return;
                end
                open_frame();
            end

            if (phase == P_CHUNKS && cur_chunk >= cc)
            begin
                phase    = P_END;
                end_seen = 0;
            end

            if (phase == P_CHUNKS)
            begin
                code = int'(size_codes[2 * (cur_chunk & 15) +: 2]);
                size = (code == 0) ? 1 : ((code == 1) ? 2 : 4);
                if (big_endian)
                    acc = {acc[23:0], b};
                else
                    acc = acc | (32'(b) << (8 * (byte_cnt & 3)));
                byte_cnt++;
                if (byte_cnt >= size)
                begin
                    m   = byte_mask(size);
                    raw = {1'b0, acc & m};
                    idx = cur_chunk;
                    fe  = 1'b0;
                    if (signed_mask[idx & 15] && raw[8 * size - 1])
                        raw = raw | ~{1'b0, m};
                    cur_chunk++;
                    byte_cnt = 0;
                    acc      = '0;
                    if (cur_chunk >= cc)
                    begin
                        if (el > 0)
                        begin
                            phase    = P_END;
                            end_seen = 0;
                        end
                        else
                        begin
                            fe = 1'b1;
                            restart_hunt();
                        end
                    end
                    post(4'(idx), raw, ST_CHUNK, fe);
                end
                return;
            end

            // end marker check; lengths shrunk mid-frame may already be met
            if (end_seen >= el)
            begin
                restart_hunt();
                post(4'd0, 33'd0, ST_DONE, 1'b1);
                return;
            end
            want = 8'(end_marker >> (8 * ((el - 1 - end_seen) & 3)));
            if (b != want)
            begin
                restart_hunt();
                post(4'd0, 33'd0, ST_MISMATCH, 1'b1);
                return;
            end
            end_seen++;
            if (end_seen >= el)
            begin
                restart_hunt();
                post(4'd0, 33'd0, ST_DONE, 1'b1);
            end
        endfunction

        function void match_result(logic [39:0] data, logic last);
            chunk_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got data=%h last=%0d",
                         $time, data, last);
                return;
            end
            want = pending_results.pop_front();
            if (data[3:0] != want.idx)
            begin
                errors++;
                $display("%0t: chunk_index expected %0d got %0d", $time, want.idx, data[3:0]);
            end
            if (data[36:4] != want.value)
            begin
                errors++;
                $display("%0t: chunk_value expected %0d got %0d", $time,
                         $signed(want.value), $signed(data[36:4]));
            end
            if (data[38:37] != want.status)
            begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, want.status, data[38:37]);
            end
            if (last != want.fe)
            begin
                errors++;
                $display("%0t: frame_end expected %0d got %0d", $time, want.fe, last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // data_byte[7:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // chunk_index[3:0], chunk_value[36:4], status[38:37], zero pad
    logic        m_tlast;    // frame_end
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [31:0] wr_data;

    chunk_scoreboard model;
    bit              calm;
    int              cycles = 0;
    int              frame_bytes;
    logic [7:0]      script[$];

    marker_chunk_deframer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // results are checked before the byte of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                model.match_result(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                model.take_byte(s_tdata);
        end
    end

    // result side: random stall before each item unless in a calm stretch
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 3);
            repeat (n)
            begin
                @(negedge clk);
                m_tready = 1'b0;
            end
            @(negedge clk);
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_script();
        foreach (script[i])
            send_byte(script[i]);
    endtask

    // hold off the sender until all results are out and the parser has settled
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = data;
        model.write_reg(idx, data);
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    function automatic logic [7:0] payload_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hff;
        return 8'($urandom);
    endfunction

    task automatic pick_config(input int p);
        logic [31:0] sm, em, codes;
        logic [2:0]  sl, el;
        logic [4:0]  cc;
        logic        be;
        logic [15:0] mask;
        sm    = $urandom;
        em    = $urandom;
        codes = $urandom;
        mask  = 16'($urandom);
        be    = 1'($urandom_range(0, 1));
        sl    = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        el    = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        cc    = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(0, 5));
        if (p == 1)
        begin
            sm = '1; em = '1; sl = 3'd4; el = 3'd4; cc = 5'd16;
            codes = '1; mask = '1; be = 1'b1;
        end
        else if (p == 2)
        begin
            sm = '0; em = '0; sl = 3'd1; el = 3'd0; cc = 5'd1;
            codes = '0; mask = '0; be = 1'b0;
        end
        set_register(REG_START_MARKER, sm);
        set_register(REG_START_LENGTH, 32'(sl));
        set_register(REG_END_MARKER, em);
        set_register(REG_END_LENGTH, 32'(el));
        set_register(REG_CHUNK_COUNT, 32'(cc));
        set_register(REG_SIZE_CODES, codes);
        set_register(REG_BIG_ENDIAN, 32'(be));
        set_register(REG_SIGNED_MASK, 32'(mask));
    endtask

    // one frame for the current settings: optional noise, marker, payload, end marker;
    // the end marker is sometimes corrupted and the frame sometimes cut short
    task automatic send_frame(input bit cut);
        int         sl, el, cc, code, k, noise, keep;
        logic [7:0] seq[$];
        sl = (model.start_len > 4) ? 4 : int'(model.start_len);
        el = (model.end_len > 4) ? 4 : int'(model.end_len);
        cc = (model.chunk_count > 16) ? 16 : int'(model.chunk_count);
        noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (noise)
            seq.push_back(payload_byte());
        for (k = 0; k < sl; k++)
            seq.push_back(8'(model.start_marker >> (8 * (sl - 1 - k))));
        for (k = 0; k < cc; k++)
        begin
            code = int'(model.size_codes[2 * k +: 2]);
            repeat ((code == 0) ? 1 : ((code == 1) ? 2 : 4))
                seq.push_back(payload_byte());
        end
        for (k = 0; k < el; k++)
            seq.push_back(8'(model.end_marker >> (8 * (el - 1 - k))));
        if (el > 0 && $urandom_range(0, 5) == 0)
        begin
            k = seq.size() - 1 - $urandom_range(0, el - 1);
            seq[k] = seq[k] ^ 8'($urandom_range(1, 255));
        end
        if (seq.size() == 0)
            seq.push_back(payload_byte());
        keep = cut ? $urandom_range(1, seq.size()) : seq.size();
        for (k = 0; k < keep; k++)
            send_byte(seq[k]);
        frame_bytes += (keep > noise) ? keep - noise : 0;
    endtask

    initial
    begin
        int p, budget;
        model       = new();
        calm        = 1'b0;
        frame_bytes = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        wr_en       = 1'b0;
        wr_index    = REG_START_MARKER;
        wr_data     = 32'h0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: no marker, no chunks, no end check
        send_byte(8'hff);
        wait_idle();

        // oversized start length acts as four bytes; marker alone completes the frame
        set_register(REG_START_MARKER, 32'hdead_beef);
        set_register(REG_START_LENGTH, 32'd7);
        script = {8'hde, 8'had, 8'hbe, 8'hef};
        send_script();
        wait_idle();

        // sizes 1, 2, 4 in host order, chunks 0 and 2 signed, one end byte
        set_register(REG_START_LENGTH, 32'd1);
        set_register(REG_CHUNK_COUNT, 32'd3);
        set_register(REG_SIZE_CODES, 32'h24);
        set_register(REG_SIGNED_MASK, 32'h5);
        set_register(REG_END_MARKER, 32'h55);
        set_register(REG_END_LENGTH, 32'd1);
        script = {8'hef, 8'h80, 8'hff, 8'h7f, 8'h01, 8'h02, 8'h03, 8'h84, 8'h55};
        send_script();
        wait_idle();

        // network order, end marker broken at its second byte
        set_register(REG_BIG_ENDIAN, 32'd1);
        set_register(REG_END_MARKER, 32'h0055_aa33);
        set_register(REG_END_LENGTH, 32'd3);
        script = {8'hef, 8'h00, 8'h80, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h55, 8'h00};
        send_script();
        wait_idle();

        // settings changed in the middle of a chunk, then no end check
        script = {8'hef, 8'h12, 8'h34};
        send_script();
        wait_idle();
        set_register(REG_CHUNK_COUNT, 32'd2);
        set_register(REG_SIZE_CODES, 32'h0);
        set_register(REG_END_LENGTH, 32'd0);
        send_byte(8'h56);
        wait_idle();

        for (p = 0; frame_bytes < RANDOM_BYTES; p++)
        begin
            calm = (p % 4 == 3);
            pick_config(p);
            budget = frame_bytes + 55;
            while (frame_bytes < budget)
                send_frame(1'b0);
            if ($urandom_range(0, 2) == 0)
                send_frame(1'b1);
            wait_idle();
        end

        if (model.errors == 0 && model.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
